// File: hdl/lfdc_pkg.sv
`default_nettype none
package lfdc_pkg;

	localparam int LEVEL_BITS_DEF    = 8;
	localparam int DISTANCE_BITS_DEF = 12;
	localparam int OFFSET_BITS       = 7;
	localparam int LANE_TYPE_BITS    = 2;
	localparam int COUNT_BITS        = 8;
	localparam int SECTORS           = 5;
	localparam int CFG_INDEX_BITS    = 3;
	localparam int CFG_DATA_BITS     = 16;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_LOW_LEVEL       = 3'd0,
		REG_MIDDLE_LEVEL    = 3'd1,
		REG_HIGH_LEVEL      = 3'd2,
		REG_RAMP_STEP       = 3'd3,
		REG_STOP_DISTANCE   = 3'd4,
		REG_LOST_LANE_LIMIT = 3'd5,
		REG_TEST_BYPASS     = 3'd6
	} cfg_reg_t;

	localparam logic [LANE_TYPE_BITS-1:0] LANE_VALID = 2'd0;
	localparam logic [LANE_TYPE_BITS-1:0] LANE_NONE  = 2'd1;

	localparam logic signed [OFFSET_BITS-1:0] OFF_CENTER    = 7'sd0;
	localparam logic signed [OFFSET_BITS-1:0] OFF_RIGHT_MID = 7'sd10;
	localparam logic signed [OFFSET_BITS-1:0] OFF_RIGHT_FAR = 7'sd20;
	localparam logic signed [OFFSET_BITS-1:0] OFF_LEFT_MID  = -7'sd10;
	localparam logic signed [OFFSET_BITS-1:0] OFF_LEFT_FAR  = -7'sd20;
	localparam logic signed [OFFSET_BITS-1:0] OFF_EDGE_POS  = 7'sd15;
	localparam logic signed [OFFSET_BITS-1:0] OFF_EDGE_NEG  = -7'sd15;

	localparam int RST_LOW_LEVEL       = -50;
	localparam int RST_MIDDLE_LEVEL    = -5;
	localparam int RST_HIGH_LEVEL      = 50;
	localparam int RST_RAMP_STEP       = 10;
	localparam int RST_STOP_DISTANCE   = 45;
	localparam int RST_LOST_LANE_LIMIT = 100;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

endpackage
`default_nettype wire

// File: hdl/lfdc_ifs.sv
`default_nettype none
interface lfdc_in_if #(
	parameter int DISTANCE_BITS = lfdc_pkg::DISTANCE_BITS_DEF
);
	logic                                      valid;
	logic                                      ready;
	logic signed [lfdc_pkg::OFFSET_BITS-1:0]   lane_offset;
	logic [lfdc_pkg::LANE_TYPE_BITS-1:0]       lane_type;
	logic                                      scan_complete;
	logic [DISTANCE_BITS-1:0]                  distance_0;
	logic [DISTANCE_BITS-1:0]                  distance_1;
	logic [DISTANCE_BITS-1:0]                  distance_2;
	logic [DISTANCE_BITS-1:0]                  distance_3;
	logic [DISTANCE_BITS-1:0]                  distance_4;

	modport source (
		output valid, lane_offset, lane_type, scan_complete,
		output distance_0, distance_1, distance_2, distance_3, distance_4,
		input  ready
	);
	modport sink (
		input  valid, lane_offset, lane_type, scan_complete,
		input  distance_0, distance_1, distance_2, distance_3, distance_4,
		output ready
	);
endinterface

interface lfdc_out_if #(
	parameter int LEVEL_BITS = lfdc_pkg::LEVEL_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          motor_enable;
	logic                          obstacle_seen;
	logic signed [LEVEL_BITS-1:0]  right_drive;
	logic signed [LEVEL_BITS-1:0]  left_drive;

	modport source (
		output valid, motor_enable, obstacle_seen, right_drive, left_drive,
		input  ready
	);
	modport sink (
		input  valid, motor_enable, obstacle_seen, right_drive, left_drive,
		output ready
	);
endinterface

interface lfdc_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [lfdc_pkg::CFG_INDEX_BITS-1:0]   index;
	logic [lfdc_pkg::CFG_DATA_BITS-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/lfdc_ramp.sv
`default_nettype none
module lfdc_ramp #(
	parameter int LEVEL_BITS = lfdc_pkg::LEVEL_BITS_DEF
) (
	input  wire logic signed [LEVEL_BITS-1:0] level,
	input  wire logic signed [LEVEL_BITS-1:0] target,
	input  wire logic        [LEVEL_BITS-2:0] step,
	output      logic signed [LEVEL_BITS-1:0] next_level
);

	logic signed [LEVEL_BITS:0] level_x;
	logic signed [LEVEL_BITS:0] target_x;
	logic signed [LEVEL_BITS:0] step_x;
	logic signed [LEVEL_BITS:0] diff;
	logic signed [LEVEL_BITS:0] up;
	logic signed [LEVEL_BITS:0] down;

	assign level_x  = (LEVEL_BITS+1)'(level);
	assign target_x = (LEVEL_BITS+1)'(target);
	assign step_x   = signed'({2'b00, step});
	assign diff     = target_x - level_x;
	assign up       = level_x + step_x;
	assign down     = level_x - step_x;

	always_comb begin
		if (diff >= 0) begin
			next_level = (diff < step_x) ? target : up[LEVEL_BITS-1:0];
		end else begin
			next_level = (diff > -step_x) ? target : down[LEVEL_BITS-1:0];
		end
	end

endmodule
`default_nettype wire

// File: hdl/line_follower_drive_controller_unit.sv
// Lane-following drive controller. One sensor tick (lane offset, lane type, scan flag and five
// range readings) yields one drive beat: motor enable, obstacle flag and the ramped right and
// left drive levels. A tick can be taken every clock cycle unless drive.ready holds back a
// waiting beat. Each tick lands in the input register, then in the result register, and the
// stop/run state, no-lane count, targets and levels are updated in the single stage between
// them (held while the test bypass is set) so the next tick sees them at once. The user must
// write registers through the cfg channel only while no tick is in flight; it is not enforced.
`default_nettype none
module line_follower_drive_controller_unit #(
	parameter int LEVEL_BITS    = lfdc_pkg::LEVEL_BITS_DEF,
	parameter int DISTANCE_BITS = lfdc_pkg::DISTANCE_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	lfdc_in_if.sink   sensor,
	lfdc_out_if.source drive,
	lfdc_cfg_if.sink  cfg
);

	localparam int OB = lfdc_pkg::OFFSET_BITS;
	localparam int CB = lfdc_pkg::COUNT_BITS;
	localparam int NS = lfdc_pkg::SECTORS;

	// configuration
	logic signed [LEVEL_BITS-1:0]    low_level_q;
	logic signed [LEVEL_BITS-1:0]    middle_level_q;
	logic signed [LEVEL_BITS-1:0]    high_level_q;
	logic        [LEVEL_BITS-2:0]    ramp_step_q;
	logic        [DISTANCE_BITS-1:0] stop_distance_q;
	logic        [CB-1:0]            lost_lane_limit_q;
	logic                            test_bypass_q;

	// control state
	logic                            running_q;
	logic        [CB-1:0]            lost_count_q;
	logic signed [LEVEL_BITS-1:0]    right_target_q;
	logic signed [LEVEL_BITS-1:0]    left_target_q;
	logic signed [LEVEL_BITS-1:0]    right_level_q;
	logic signed [LEVEL_BITS-1:0]    left_level_q;

	// input stage
	logic                            valid_s1;
	logic signed [OB-1:0]            offset_s1;
	logic [lfdc_pkg::LANE_TYPE_BITS-1:0] type_s1;
	logic                            scan_s1;
	logic        [DISTANCE_BITS-1:0] dist_s1 [NS];

	// result stage
	logic                            valid_s2;
	logic                            enable_s2;
	logic                            obstacle_s2;
	logic signed [LEVEL_BITS-1:0]    right_s2;
	logic signed [LEVEL_BITS-1:0]    left_s2;

	logic                            advance;
	logic [NS-1:0]                   near;
	logic                            obstacle;
	logic                            running_d;
	logic        [CB-1:0]            lost_count_d;
	logic signed [LEVEL_BITS-1:0]    right_target_d;
	logic signed [LEVEL_BITS-1:0]    left_target_d;
	logic signed [LEVEL_BITS-1:0]    right_ramped;
	logic signed [LEVEL_BITS-1:0]    left_ramped;
	logic signed [LEVEL_BITS-1:0]    right_level_d;
	logic signed [LEVEL_BITS-1:0]    left_level_d;

	assign advance      = valid_s1 && (!valid_s2 || drive.ready);
	assign sensor.ready = !valid_s1 || advance;
	assign cfg.ready    = 1'b1;

	assign drive.valid         = valid_s2;
	assign drive.motor_enable  = enable_s2;
	assign drive.obstacle_seen = obstacle_s2;
	assign drive.right_drive   = right_s2;
	assign drive.left_drive    = left_s2;

	// obstacle from three sectors facing the lane (not at offset +/-15); set if no scan
	always_comb begin
		for (int i = 0; i < NS; i++) begin
			near[i] = dist_s1[i] < stop_distance_q;
		end
		if (!scan_s1) begin
			obstacle = 1'b1;
		end else if (offset_s1 < lfdc_pkg::OFF_EDGE_NEG) begin
			obstacle = near[0] || near[1] || near[2];
		end else if (offset_s1 > lfdc_pkg::OFF_EDGE_POS) begin
			obstacle = near[2] || near[3] || near[4];
		end else if (offset_s1 != lfdc_pkg::OFF_EDGE_NEG &&
		             offset_s1 != lfdc_pkg::OFF_EDGE_POS) begin
			obstacle = near[1] || near[2] || near[3];
		end else begin
			obstacle = 1'b0;
		end
	end

	// stop/run machine and no-lane count
	always_comb begin
		running_d    = running_q;
		lost_count_d = lost_count_q;
		if (!running_q) begin
			if (!obstacle && type_s1 == lfdc_pkg::LANE_VALID) begin
				running_d = 1'b1;
			end
		end else begin
			if (type_s1 == lfdc_pkg::LANE_NONE) begin
				if (lost_count_q != lfdc_pkg::COUNT_MAX) begin
					lost_count_d = lost_count_q + 1'b1;
				end
			end else begin
				lost_count_d = '0;
			end
			if (obstacle || lost_count_d > lost_lane_limit_q) begin
				running_d = 1'b0;
			end
		end
	end

	// drive targets from the lane offset
	always_comb begin
		right_target_d = right_target_q;
		left_target_d  = left_target_q;
		case (offset_s1)
			lfdc_pkg::OFF_CENTER: begin
				right_target_d = high_level_q;
				left_target_d  = high_level_q;
			end
			lfdc_pkg::OFF_RIGHT_MID: begin
				right_target_d = middle_level_q;
				left_target_d  = high_level_q;
			end
			lfdc_pkg::OFF_RIGHT_FAR: begin
				right_target_d = low_level_q;
				left_target_d  = high_level_q;
			end
			lfdc_pkg::OFF_LEFT_MID: begin
				right_target_d = high_level_q;
				left_target_d  = middle_level_q;
			end
			lfdc_pkg::OFF_LEFT_FAR: begin
				right_target_d = high_level_q;
				left_target_d  = low_level_q;
			end
			default: begin
				right_target_d = right_target_q;
				left_target_d  = left_target_q;
			end
		endcase
	end

	lfdc_ramp #(.LEVEL_BITS(LEVEL_BITS)) u_ramp_right (
		.level      (right_level_q),
		.target     (right_target_d),
		.step       (ramp_step_q),
		.next_level (right_ramped)
	);

	lfdc_ramp #(.LEVEL_BITS(LEVEL_BITS)) u_ramp_left (
		.level      (left_level_q),
		.target     (left_target_d),
		.step       (ramp_step_q),
		.next_level (left_ramped)
	);

	assign right_level_d = test_bypass_q ? right_level_q : right_ramped;
	assign left_level_d  = test_bypass_q ? left_level_q  : left_ramped;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_level_q       <= LEVEL_BITS'(lfdc_pkg::RST_LOW_LEVEL);
			middle_level_q    <= LEVEL_BITS'(lfdc_pkg::RST_MIDDLE_LEVEL);
			high_level_q      <= LEVEL_BITS'(lfdc_pkg::RST_HIGH_LEVEL);
			ramp_step_q       <= (LEVEL_BITS-1)'(lfdc_pkg::RST_RAMP_STEP);
			stop_distance_q   <= DISTANCE_BITS'(lfdc_pkg::RST_STOP_DISTANCE);
			lost_lane_limit_q <= CB'(lfdc_pkg::RST_LOST_LANE_LIMIT);
			test_bypass_q     <= 1'b0;
		end else if (cfg.valid) begin
			case (lfdc_pkg::cfg_reg_t'(cfg.index))
				lfdc_pkg::REG_LOW_LEVEL: begin
					low_level_q <= cfg.data[LEVEL_BITS-1:0];
				end
				lfdc_pkg::REG_MIDDLE_LEVEL: begin
					middle_level_q <= cfg.data[LEVEL_BITS-1:0];
				end
				lfdc_pkg::REG_HIGH_LEVEL: begin
					high_level_q <= cfg.data[LEVEL_BITS-1:0];
				end
				lfdc_pkg::REG_RAMP_STEP: begin
					ramp_step_q <= cfg.data[LEVEL_BITS-2:0];
				end
				lfdc_pkg::REG_STOP_DISTANCE: begin
					stop_distance_q <= cfg.data[DISTANCE_BITS-1:0];
				end
				lfdc_pkg::REG_LOST_LANE_LIMIT: begin
					lost_lane_limit_q <= cfg.data[CB-1:0];
				end
				lfdc_pkg::REG_TEST_BYPASS: begin
					test_bypass_q <= cfg.data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sensor.ready) begin
			valid_s1 <= sensor.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sensor.valid && sensor.ready) begin
			offset_s1  <= sensor.lane_offset;
			type_s1    <= sensor.lane_type;
			scan_s1    <= sensor.scan_complete;
			dist_s1[0] <= sensor.distance_0;
			dist_s1[1] <= sensor.distance_1;
			dist_s1[2] <= sensor.distance_2;
			dist_s1[3] <= sensor.distance_3;
			dist_s1[4] <= sensor.distance_4;
		end
	end

	// control state, held while the test bypass is set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q      <= 1'b0;
			lost_count_q   <= '0;
			right_target_q <= '0;
			left_target_q  <= '0;
			right_level_q  <= '0;
			left_level_q   <= '0;
		end else if (advance && !test_bypass_q) begin
			running_q      <= running_d;
			lost_count_q   <= lost_count_d;
			right_target_q <= right_target_d;
			left_target_q  <= left_target_d;
			right_level_q  <= right_level_d;
			left_level_q   <= left_level_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (drive.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			enable_s2   <= test_bypass_q ? running_q : running_d;
			obstacle_s2 <= obstacle;
			right_s2    <= right_level_d;
			left_s2     <= left_level_d;
		end
	end

endmodule
`default_nettype wire
